@@ rtl/core/lnser_pkg.sv @@
`timescale 1ns / 1ps

package lnser_pkg;

  // line select codes
  localparam logic LINE_FREQ = 1'b0;
  localparam logic LINE_RES  = 1'b1;

  // display bytes
  localparam logic [7:0] CMD_FREQ_LINE = 8'h80;
  localparam logic [7:0] CMD_RES_LINE  = 8'hC0;
  localparam logic [7:0] CH_F          = 8'h46;
  localparam logic [7:0] CH_R          = 8'h52;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_H          = 8'h48;
  localparam logic [7:0] CH_Z          = 8'h7A;
  localparam logic [7:0] CH_OHM        = 8'hF4;
  localparam logic [3:0] DIGIT_HI      = 4'h3;
  localparam logic [7:0] DIGIT_BASE    = 8'h30;

  // bus byte control nibbles (enable, register select)
  localparam logic [3:0] CTL_CMD_LO  = 4'h0;
  localparam logic [3:0] CTL_CMD_HI  = 4'h8;
  localparam logic [3:0] CTL_DATA_LO = 4'h4;
  localparam logic [3:0] CTL_DATA_HI = 4'hC;

  // character positions in a line
  localparam int unsigned       CHAR_IDX_W = 4;
  localparam logic [CHAR_IDX_W-1:0] LAST_IDX_FREQ = 4'd8;
  localparam logic [CHAR_IDX_W-1:0] LAST_IDX_RES  = 4'd7;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  // one classified line, digits already split out
  typedef struct packed {
    logic       cmd;
    logic [7:0] lead_char;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } line_entry_t;

  function automatic logic [7:0] line_char(input line_entry_t ent,
                                           input logic [CHAR_IDX_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      4'd0:    ch = (ent.cmd == LINE_RES) ? CMD_RES_LINE : CMD_FREQ_LINE;
      4'd1:    ch = (ent.cmd == LINE_RES) ? CH_R : CH_F;
      4'd2:    ch = CH_COLON;
      4'd3:    ch = ent.lead_char;
      4'd4:    ch = {DIGIT_HI, ent.hun};
      4'd5:    ch = {DIGIT_HI, ent.ten};
      4'd6:    ch = {DIGIT_HI, ent.one};
      4'd7:    ch = (ent.cmd == LINE_RES) ? CH_OHM : CH_H;
      4'd8:    ch = CH_Z;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/lnser_front.sv @@
`timescale 1ns / 1ps

module lnser_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lnser_pkg::in_item_t    in_data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output lnser_pkg::line_entry_t push_entry
);

  typedef enum logic [2:0] {
    F_IDLE, F_QUO, F_REM, F_HUN, F_TEN, F_ONE, F_PUSH
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic        cmd_r;
  logic [15:0] val_r;
  logic [6:0]  quo_r;     // value / 1000
  logic [3:0]  quo_t_r;   // quo / 10
  logic [9:0]  rem_r;     // value % 1000
  logic [3:0]  hun_r;
  logic [6:0]  sub_r;     // rem % 100
  logic [3:0]  ten_r;
  logic [7:0]  lead_r;

  logic [32:0] quo_prod;
  logic [17:0] quo_t_prod;
  logic [16:0] quo_k;
  logic [15:0] hun_prod;
  logic [9:0]  hun_k;
  logic [14:0] ten_prod;
  logic [6:0]  ten_k;
  logic [6:0]  quo_m;
  logic [6:0]  one_full;
  logic [16:0] rem_full;
  logic [9:0]  sub_full;

  // reciprocal multiplies, each exact over its input range
  assign quo_prod   = {17'd0, val_r} * 33'd67109;
  assign quo_k      = {10'd0, quo_r} * 17'd1000;
  assign rem_full   = {1'b0, val_r} - quo_k;
  assign quo_t_prod = {11'd0, quo_r} * 18'd205;
  assign hun_prod   = {6'd0, rem_r} * 16'd41;
  assign hun_k      = {6'd0, hun_r} * 10'd100;
  assign sub_full   = rem_r - hun_k;
  assign ten_prod   = {8'd0, sub_r} * 15'd205;
  assign ten_k      = {3'd0, ten_r} * 7'd10;
  assign one_full   = sub_r - ten_k;
  assign quo_m      = quo_r - ({3'd0, quo_t_r} * 7'd10);

  assign in_stall   = (state_r != F_IDLE);
  assign push_valid = (state_r == F_PUSH);

  always_comb begin
    push_entry.cmd       = cmd_r;
    push_entry.lead_char = lead_r;
    push_entry.hun       = hun_r;
    push_entry.ten       = ten_r;
    push_entry.one       = one_full[3:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_QUO;
      F_QUO:   state_nxt = F_REM;
      F_REM:   state_nxt = F_HUN;
      F_HUN:   state_nxt = F_TEN;
      F_TEN:   state_nxt = F_ONE;
      F_ONE:   state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      cmd_r <= in_data.cmd;
      val_r <= in_data.value;
    end
    if (state_r == F_QUO) begin
      quo_r <= quo_prod[32:26];
    end
    if (state_r == F_REM) begin
      rem_r   <= rem_full[9:0];
      quo_t_r <= quo_t_prod[14:11];
    end
    if (state_r == F_HUN) begin
      hun_r <= hun_prod[15:12];
      // resistance line keeps the full quotient, frequency line one digit
      if (cmd_r == lnser_pkg::LINE_RES) begin
        lead_r <= {1'b0, quo_r} + lnser_pkg::DIGIT_BASE;
      end else begin
        lead_r <= {lnser_pkg::DIGIT_HI, quo_m[3:0]};
      end
    end
    if (state_r == F_TEN) begin
      sub_r <= sub_full[6:0];
    end
    if (state_r == F_ONE) begin
      ten_r <= ten_prod[14:11];
    end
  end

endmodule

@@ rtl/core/lnser_queue.sv @@
`timescale 1ns / 1ps

module lnser_queue #(
  parameter int unsigned DEPTH = lnser_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  lnser_pkg::line_entry_t push_entry,
  output logic                   pop_valid,
  input  logic                   pop,
  output lnser_pkg::line_entry_t pop_entry
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lnser_pkg::line_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/core/lnser_back.sv @@
`timescale 1ns / 1ps

module lnser_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop,
  input  lnser_pkg::line_entry_t pop_entry,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lnser_pkg::out_item_t   out_data
);

  localparam int unsigned IW = lnser_pkg::CHAR_IDX_W;

  logic                   busy_r;
  lnser_pkg::line_entry_t ent_r;
  logic [IW-1:0]          idx_r;
  logic                   nib_r;   // 0 high nibble, 1 low nibble
  logic [1:0]             ph_r;    // enable pulse phase
  logic                   out_valid_r;
  lnser_pkg::out_item_t   out_data_r;

  logic          adv;
  logic [7:0]    ch;
  logic [3:0]    nib;
  logic          is_data;
  logic [3:0]    ctl;
  logic [IW-1:0] last_idx;
  logic          is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign adv      = busy_r && (!out_valid_r || !out_stall);
  assign pop      = !busy_r && pop_valid;
  assign ch       = lnser_pkg::line_char(ent_r, idx_r);
  assign nib      = nib_r ? ch[3:0] : ch[7:4];
  assign is_data  = (idx_r != '0);
  assign last_idx = (ent_r.cmd == lnser_pkg::LINE_RES) ? lnser_pkg::LAST_IDX_RES
                                                       : lnser_pkg::LAST_IDX_FREQ;
  assign is_last  = (idx_r == last_idx) && nib_r && (ph_r == 2'd2);

  always_comb begin
    if (ph_r == 2'd1) begin
      ctl = is_data ? lnser_pkg::CTL_DATA_HI : lnser_pkg::CTL_CMD_HI;
    end else begin
      ctl = is_data ? lnser_pkg::CTL_DATA_LO : lnser_pkg::CTL_CMD_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      nib_r       <= 1'b0;
      ph_r        <= '0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        nib_r  <= 1'b0;
        ph_r   <= '0;
      end else if (adv) begin
        if (ph_r == 2'd2) begin
          ph_r  <= '0;
          nib_r <= ~nib_r;
          if (nib_r) begin
            idx_r <= idx_r + 1'b1;
          end
        end else begin
          ph_r <= ph_r + 1'b1;
        end
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= pop_entry;
    end
    if (adv) begin
      out_data_r.bus_byte <= {ctl, nib};
      out_data_r.last     <= is_last;
    end
  end

endmodule

@@ rtl/core/lcd_numeric_line_serializer_core.sv @@
`timescale 1ns / 1ps

// Turns a line request (line select plus 16-bit value) into the bus bytes for a
// 4-bit character LCD behind a serial shifter: cursor command, label, digits and
// suffix, each byte as two nibbles of three bytes that pulse enable. A frequency
// line is 54 bytes, a resistance line 48. The byte sequencer sends one byte per
// cycle while the output is not stalled, and goes idle after each line to load the
// next line from the queue; that sequencer sets the sustained rate. The digit
// front end splits each request into digits through its divide-by-constant stages
// and takes no new request until the current one is pushed; it hands lines to the
// sequencer through a small queue, so it prepares the next request while the
// current line is still going out. The last byte of each line carries last = 1.
module lcd_numeric_line_serializer_core #(
  parameter int unsigned QUEUE_DEPTH = lnser_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lnser_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lnser_pkg::out_item_t out_data
);

  logic                   push_valid, push_ready;
  lnser_pkg::line_entry_t push_entry;
  logic                   pop_valid, pop;
  lnser_pkg::line_entry_t pop_entry;

  lnser_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  lnser_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  lnser_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
